// ===== rtl/dit_pkg.sv =====
// Shared types and constants for the delimited integer text parser.
`timescale 1ns / 1ps
`default_nettype none
package dit_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// register indexes (paddr[5:3])
	localparam logic [2:0] REG_DELIM_0 = 3'd0;
	localparam logic [2:0] REG_DELIM_1 = 3'd1;
	localparam logic [2:0] REG_DELIM_2 = 3'd2;
	localparam logic [2:0] REG_DELIM_3 = 3'd3;
	localparam logic [2:0] REG_MAX_NUM = 3'd4;

	// result status codes
	localparam logic [2:0] ST_NUMBER      = 3'd0;
	localparam logic [2:0] ST_NON_NUMERIC = 3'd1;
	localparam logic [2:0] ST_RANGE       = 3'd2;
	localparam logic [2:0] ST_END         = 3'd3;
	localparam logic [2:0] ST_EMPTY       = 3'd4;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [1:0]  LEN_CAP = 2'd2;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// one classified byte
	typedef struct packed {
		logic       delim;
		logic       digit;
		logic [3:0] dval;
		logic       sign;
		logic       minus;
		logic       eos;
	} dit_class_t;

endpackage
`default_nettype wire

// ===== rtl/dit_front.sv =====
// Front end: delimiter lookup and character classification of each input byte.
`timescale 1ns / 1ps
`default_nettype none
module dit_front (
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_string,
	input  wire logic [63:0]         delim_mask_0,
	input  wire logic [63:0]         delim_mask_1,
	input  wire logic [63:0]         delim_mask_2,
	input  wire logic [63:0]         delim_mask_3,
	output dit_pkg::dit_class_t      cls
);

	logic [63:0] mask_sel;
	logic [7:0]  dv;

	always_comb begin
		case (text_byte[7:6])
			2'd0: mask_sel = delim_mask_0;
			2'd1: mask_sel = delim_mask_1;
			2'd2: mask_sel = delim_mask_2;
			default: mask_sel = delim_mask_3;
		endcase
	end

	assign dv = text_byte - dit_pkg::CHAR_ZERO;

	always_comb begin
		cls.delim = mask_sel[text_byte[5:0]];
		cls.digit = (text_byte >= dit_pkg::CHAR_ZERO) && (text_byte <= dit_pkg::CHAR_NINE);
		cls.dval  = dv[3:0];
		cls.sign  = (text_byte == dit_pkg::CHAR_MINUS) || (text_byte == dit_pkg::CHAR_PLUS);
		cls.minus = (text_byte == dit_pkg::CHAR_MINUS);
		cls.eos   = end_of_string;
	end

endmodule
`default_nettype wire

// ===== rtl/dit_queue.sv =====
// Short queue of classified bytes between front end and token engine.
`timescale 1ns / 1ps
`default_nettype none
module dit_queue #(
	parameter int DEPTH = dit_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  dit_pkg::dit_class_t      push_data,
	output logic                     full,
	input  wire logic                pop,
	output logic                     q_valid,
	output dit_pkg::dit_class_t      q_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	dit_pkg::dit_class_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == FULL_CNT);
	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dit_back.sv =====
// Token engine: accumulates digits, closes tokens and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module dit_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  dit_pkg::dit_class_t      q_data,
	output logic                     pop,
	input  wire logic [15:0]         num_limit,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       number,
	output logic [2:0]               status,
	output logic                     last
);

	// token state
	logic        in_token_q;
	logic [1:0]  len_q;
	logic        first_sign_q;
	logic        neg_q;
	logic        not_num_q;
	logic [31:0] mag_q;
	logic        ovf_q;
	logic [15:0] cnt_q;
	logic        any_seen_q;

	logic        out_valid_q;
	logic [31:0] number_q;
	logic [2:0]  status_q;
	logic        last_q;

	// token state after this byte
	logic        t_in;
	logic [1:0]  t_len;
	logic        t_fs;
	logic        t_neg;
	logic        t_nn;
	logic [31:0] t_mag;
	logic        t_ovf;

	logic [31:0] acc_base;
	logic [34:0] acc_wide;
	logic [31:0] acc_mag;
	logic        acc_ovf;

	logic        fin;
	logic        limit_hit;
	logic        emit_tok;
	logic        has_res;
	logic [31:0] tok_num;
	logic [2:0]  tok_st;
	logic [31:0] res_num;
	logic [2:0]  res_st;

	dit_pkg::dit_class_t c;

	assign c   = q_data;
	assign pop = q_valid && (!out_valid_q || !out_stall);

	// magnitude * 10 + digit as two shifted adds
	assign acc_base = in_token_q ? mag_q : '0;
	assign acc_wide = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {31'd0, c.dval};
	assign acc_ovf  = (acc_wide > {3'b000, dit_pkg::MAG_CAP});
	assign acc_mag  = acc_ovf ? dit_pkg::MAG_CAP : acc_wide[31:0];

	always_comb begin
		t_in  = in_token_q;
		t_len = len_q;
		t_fs  = first_sign_q;
		t_neg = neg_q;
		t_nn  = not_num_q;
		t_mag = mag_q;
		t_ovf = ovf_q;
		if (!c.delim) begin
			if (!in_token_q) begin
				t_in  = 1'b1;
				t_len = 2'd1;
				t_fs  = c.sign;
				t_neg = c.minus;
				t_nn  = !c.digit && !c.sign;
				t_mag = c.digit ? acc_mag : '0;
				t_ovf = 1'b0;
			end else begin
				if (c.digit) begin
					t_mag = acc_mag;
					t_ovf = ovf_q | acc_ovf;
				end else begin
					t_nn = 1'b1;
				end
				t_len = (len_q < dit_pkg::LEN_CAP) ? len_q + 2'd1 : len_q;
			end
		end
	end

	always_comb begin
		if (t_nn || (t_fs && (t_len < dit_pkg::LEN_CAP))) begin
			tok_st  = dit_pkg::ST_NON_NUMERIC;
			tok_num = '0;
		end else if (t_neg) begin
			tok_st  = t_ovf ? dit_pkg::ST_RANGE : dit_pkg::ST_NUMBER;
			tok_num = t_ovf ? dit_pkg::MAG_CAP : (32'd0 - t_mag);
		end else if (t_ovf || (t_mag >= dit_pkg::MAG_CAP)) begin
			tok_st  = dit_pkg::ST_RANGE;
			tok_num = dit_pkg::POS_MAX;
		end else begin
			tok_st  = dit_pkg::ST_NUMBER;
			tok_num = t_mag;
		end
	end

	assign fin       = t_in && (c.delim || c.eos);
	assign limit_hit = (num_limit != '0) && (cnt_q >= num_limit);
	assign emit_tok  = fin && !limit_hit;
	assign has_res   = emit_tok || c.eos;

	always_comb begin
		if (emit_tok) begin
			res_num = tok_num;
			res_st  = tok_st;
		end else begin
			res_num = '0;
			res_st  = (any_seen_q || fin) ? dit_pkg::ST_END : dit_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q   <= 1'b0;
			len_q        <= '0;
			first_sign_q <= 1'b0;
			neg_q        <= 1'b0;
			not_num_q    <= 1'b0;
			mag_q        <= '0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			any_seen_q   <= 1'b0;
		end else if (pop) begin
			if (c.eos) begin
				in_token_q   <= 1'b0;
				len_q        <= '0;
				first_sign_q <= 1'b0;
				neg_q        <= 1'b0;
				not_num_q    <= 1'b0;
				mag_q        <= '0;
				ovf_q        <= 1'b0;
				cnt_q        <= '0;
				any_seen_q   <= 1'b0;
			end else if (fin) begin
				in_token_q   <= 1'b0;
				len_q        <= '0;
				first_sign_q <= 1'b0;
				neg_q        <= 1'b0;
				not_num_q    <= 1'b0;
				mag_q        <= '0;
				ovf_q        <= 1'b0;
				any_seen_q   <= 1'b1;
				if (emit_tok && (cnt_q != dit_pkg::CNT_MAX)) begin
					cnt_q <= cnt_q + 16'd1;
				end
			end else begin
				in_token_q   <= t_in;
				len_q        <= t_len;
				first_sign_q <= t_fs;
				neg_q        <= t_neg;
				not_num_q    <= t_nn;
				mag_q        <= t_mag;
				ovf_q        <= t_ovf;
			end
		end
	end

	// output register: advances when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= pop && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			number_q <= res_num;
			status_q <= res_st;
			last_q   <= c.eos;
		end
	end

	assign out_valid = out_valid_q;
	assign number    = number_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== rtl/delimited_integer_text_parser.sv =====
// Delimited integer text parser: top level with configuration registers.
//
// Input channel (in_valid/in_stall) takes one string byte per transaction with
// end_of_string on the final byte. Output channel (out_valid/out_stall) gives
// number/status/last; each byte gives zero or one result, and every string
// closes with exactly one result that has last set.
// Registers sit on an APB-style port, 64-bit data at byte address 8*index:
// four delimiter masks (one bit per byte value) and the per-string token limit
// (0 = no limit). Write them only while no string is in flight.
// Throughput: one byte per cycle while out_stall does not hold the output,
// set by the token engine, which does one multiply-by-ten accumulate per byte.
// A result is registered in the output register when the token engine pops
// its byte from the queue; bytes queued ahead of it and out_stall holding the
// output register delay it.
// When out_stall holds the result, the queue of QUEUE_DEPTH classified bytes
// keeps filling; in_stall rises only when it is full.
// Reset clears control state: no delimiters, no limit, empty queue, no token.
`timescale 1ns / 1ps
`default_nettype none
module delimited_integer_text_parser #(
	parameter int QUEUE_DEPTH = dit_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 text_byte,
	input  wire logic                       end_of_string,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [31:0]              number,
	output logic [2:0]                      status,
	output logic                            last,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [dit_pkg::ADDR_W-1:0] paddr,
	input  wire logic [dit_pkg::DATA_W-1:0] pwdata,
	output logic [dit_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	logic [63:0] delim_0_q;
	logic [63:0] delim_1_q;
	logic [63:0] delim_2_q;
	logic [63:0] delim_3_q;
	logic [15:0] max_num_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	dit_pkg::dit_class_t front_cls;
	dit_pkg::dit_class_t q_data;
	logic q_full;
	logic q_valid;
	logic q_pop;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_0_q <= '0;
			delim_1_q <= '0;
			delim_2_q <= '0;
			delim_3_q <= '0;
			max_num_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				dit_pkg::REG_DELIM_0: delim_0_q <= pwdata;
				dit_pkg::REG_DELIM_1: delim_1_q <= pwdata;
				dit_pkg::REG_DELIM_2: delim_2_q <= pwdata;
				dit_pkg::REG_DELIM_3: delim_3_q <= pwdata;
				dit_pkg::REG_MAX_NUM: max_num_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dit_pkg::REG_DELIM_0: prdata = delim_0_q;
			dit_pkg::REG_DELIM_1: prdata = delim_1_q;
			dit_pkg::REG_DELIM_2: prdata = delim_2_q;
			dit_pkg::REG_DELIM_3: prdata = delim_3_q;
			dit_pkg::REG_MAX_NUM: prdata = {48'd0, max_num_q};
			default: prdata = '0;
		endcase
	end

	dit_front u_front (
		.text_byte     (text_byte),
		.end_of_string (end_of_string),
		.delim_mask_0  (delim_0_q),
		.delim_mask_1  (delim_1_q),
		.delim_mask_2  (delim_2_q),
		.delim_mask_3  (delim_3_q),
		.cls           (front_cls)
	);

	dit_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (front_cls),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	assign in_stall = q_full;

	dit_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (q_pop),
		.num_limit   (max_num_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.number      (number),
		.status      (status),
		.last        (last)
	);

`ifndef ASSERT_OFF
	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("token engine popped an empty queue");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= dit_pkg::ST_EMPTY))
		else $error("undefined status code on output");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dit_pkg::ST_END || status == dit_pkg::ST_EMPTY)
		|-> last && (number == 32'sd0))
		else $error("end or empty record without last or with nonzero number");

	a_non_numeric_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dit_pkg::ST_NON_NUMERIC) |-> (number == 32'sd0))
		else $error("non-numeric token with nonzero number");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the delimited integer text parser.
`timescale 1ns / 1ps
module tb;

	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT = 5000;
	// space and comma
	localparam logic [63:0] SPACE_COMMA = (64'd1 << 32) | (64'd1 << 44);
	localparam logic [63:0] NUMERIC_BITS = (64'h3FF << dit_pkg::CHAR_ZERO) |
		(64'd1 << dit_pkg::CHAR_PLUS) | (64'd1 << dit_pkg::CHAR_MINUS);
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	typedef struct packed {
		logic signed [31:0] number;
		logic [2:0]         status;
		logic               last;
	} parse_result_t;

	typedef struct {
		logic [7:0]         ch;
		logic               eos;
		logic               typed;
		logic signed [31:0] num;
		logic [2:0]         st;
		logic               lst;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = 8'd0;
	logic end_of_string = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] number;
	logic [2:0] status;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dit_pkg::ADDR_W-1:0] paddr = '0;
	logic [dit_pkg::DATA_W-1:0] pwdata = '0;
	logic [dit_pkg::DATA_W-1:0] prdata;
	logic pready;

	delimited_integer_text_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.number(number),
		.status(status),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of registers and parser state
	logic [63:0] delim_copy [4];
	logic [15:0] max_count;
	logic        tok_open;
	logic [1:0]  tok_len;
	logic        tok_sign_first;
	logic        tok_neg;
	logic        tok_bad;
	logic [31:0] tok_mag;
	logic        tok_ovf;
	logic [15:0] emit_cnt;
	logic        seen_token;

	parse_result_t pending_results [$];
	logic [7:0] str_bytes [$];
	logic [7:0] delim_bytes [$];
	dir_row_t dir_rows [24];
	int err_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles_req = 0;
	parse_result_t seen_res;
	parse_result_t want_res;

	function automatic logic roll(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic is_delim(logic [7:0] ch);
		logic [63:0] m;
		m = delim_copy[ch[7:6]];
		return m[ch[5:0]];
	endfunction

	task automatic clear_token();
		tok_open = 1'b0;
		tok_len = 2'd0;
		tok_sign_first = 1'b0;
		tok_neg = 1'b0;
		tok_bad = 1'b0;
		tok_mag = 32'd0;
		tok_ovf = 1'b0;
	endtask

	task automatic accumulate_digit(logic [7:0] ch);
		logic [63:0] v;
		v = {32'd0, tok_mag} * 64'd10 + {56'd0, ch - dit_pkg::CHAR_ZERO};
		if (v > {32'd0, dit_pkg::MAG_CAP}) begin
			tok_ovf = 1'b1;
			v = {32'd0, dit_pkg::MAG_CAP};
		end
		tok_mag = v[31:0];
	endtask

	task automatic close_token(input logic lst, output logic got, output parse_result_t r);
		r = '0;
		seen_token = 1'b1;
		if (tok_bad || (tok_sign_first && tok_len < dit_pkg::LEN_CAP)) begin
			r.status = dit_pkg::ST_NON_NUMERIC;
		end else if (tok_neg) begin
			r.status = tok_ovf ? dit_pkg::ST_RANGE : dit_pkg::ST_NUMBER;
			r.number = tok_ovf ? dit_pkg::MAG_CAP : 32'd0 - tok_mag;
		end else if (tok_ovf || tok_mag >= dit_pkg::MAG_CAP) begin
			r.status = dit_pkg::ST_RANGE;
			r.number = dit_pkg::POS_MAX;
		end else begin
			r.status = dit_pkg::ST_NUMBER;
			r.number = tok_mag;
		end
		r.last = lst;
		clear_token();
		got = !(max_count != 16'd0 && emit_cnt >= max_count);
		if (got && emit_cnt != dit_pkg::CNT_MAX)
			emit_cnt++;
	endtask

	// one accepted byte: update state, give the result it causes, if any
	task automatic parse_byte(input logic [7:0] ch, input logic eos,
			output logic got, output parse_result_t r);
		logic is_digit;
		got = 1'b0;
		r = '0;
		is_digit = (ch >= dit_pkg::CHAR_ZERO && ch <= dit_pkg::CHAR_NINE);
		if (is_delim(ch)) begin
			if (tok_open)
				close_token(eos, got, r);
		end else begin
			if (!tok_open) begin
				clear_token();
				tok_open = 1'b1;
				if (is_digit)
					accumulate_digit(ch);
				else if (ch == dit_pkg::CHAR_MINUS || ch == dit_pkg::CHAR_PLUS) begin
					tok_sign_first = 1'b1;
					tok_neg = (ch == dit_pkg::CHAR_MINUS);
				end else
					tok_bad = 1'b1;
			end else if (is_digit)
				accumulate_digit(ch);
			else
				tok_bad = 1'b1;
			if (tok_len < dit_pkg::LEN_CAP)
				tok_len++;
		end
		if (eos) begin
			if (!got && tok_open)
				close_token(1'b1, got, r);
			if (!got) begin
				got = 1'b1;
				r.number = 32'sd0;
				r.status = seen_token ? dit_pkg::ST_END : dit_pkg::ST_EMPTY;
				r.last = 1'b1;
			end
			clear_token();
			emit_cnt = 16'd0;
			seen_token = 1'b0;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] ch, input logic eos,
			input logic use_typed, input parse_result_t typed_res);
		logic got;
		parse_result_t res;
		while (roll(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= ch;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall);
		parse_byte(ch, eos, got, res);
		if (use_typed)
			pending_results.push_back(typed_res);
		else if (got)
			pending_results.push_back(res);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		case (idx)
			dit_pkg::REG_DELIM_0: delim_copy[0] = val;
			dit_pkg::REG_DELIM_1: delim_copy[1] = val;
			dit_pkg::REG_DELIM_2: delim_copy[2] = val;
			dit_pkg::REG_DELIM_3: delim_copy[3] = val;
			dit_pkg::REG_MAX_NUM: max_count = val[15:0];
			default: ;
		endcase
	endtask

	// wait for all outstanding results, then let the pipeline settle
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_results.size());
			err_count++;
			pending_results.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [63:0] m0, input logic [63:0] m1,
			input logic [63:0] m2, input logic [63:0] m3, input logic [15:0] maxn,
			input int spct, input int rpct, input int hold);
		drain();
		cfg_write(dit_pkg::REG_DELIM_0, m0);
		cfg_write(dit_pkg::REG_DELIM_1, m1);
		cfg_write(dit_pkg::REG_DELIM_2, m2);
		cfg_write(dit_pkg::REG_DELIM_3, m3);
		cfg_write(dit_pkg::REG_MAX_NUM, {48'd0, maxn});
		delim_bytes.delete();
		for (int v = 0; v < 256; v++)
			if (is_delim(v[7:0]))
				delim_bytes.push_back(v[7:0]);
		send_idle_pct = spct;
		recv_stall_pct = rpct;
		hold_cycles_req = hold;
	endtask

	task automatic push_delims();
		if (delim_bytes.size() != 0)
			repeat ($urandom_range(2, 1))
				str_bytes.push_back(delim_bytes[$urandom_range(delim_bytes.size() - 1, 0)]);
	endtask

	task automatic push_token();
		int kind;
		int pos;
		logic [63:0] mag;
		string digits;
		kind = $urandom_range(99, 0);
		if (kind < 70) begin
			case ($urandom_range(2, 0))
				1: str_bytes.push_back(dit_pkg::CHAR_PLUS);
				2: str_bytes.push_back(dit_pkg::CHAR_MINUS);
				default: ;
			endcase
			if (kind < 40)
				mag = 64'($urandom_range(99999, 0));
			else
				case ($urandom_range(7, 0))
					0: mag = 64'd0;
					1: mag = 64'd2147483647;
					2: mag = 64'd2147483648;
					3: mag = 64'd2147483649;
					4: mag = 64'd4294967295;
					5: mag = {$urandom, $urandom};
					6: mag = {32'd0, $urandom};
					default: mag = 64'd214748364;
				endcase
			if ($urandom_range(9, 0) == 0)
				repeat ($urandom_range(3, 1)) str_bytes.push_back(dit_pkg::CHAR_ZERO);
			digits = $sformatf("%0d", mag);
			// a stray byte somewhere in the digits
			pos = (kind >= 60) ? $urandom_range(digits.len() - 1, 0) : -1;
			for (int i = 0; i < digits.len(); i++) begin
				if (i == pos)
					str_bytes.push_back(8'($urandom_range(255, 0)));
				str_bytes.push_back(digits[i]);
			end
		end else if (kind < 80) begin
			str_bytes.push_back(roll(50) ? dit_pkg::CHAR_MINUS : dit_pkg::CHAR_PLUS);
		end else begin
			repeat ($urandom_range(4, 1)) str_bytes.push_back(8'($urandom_range(255, 0)));
		end
	endtask

	task automatic random_strings(input int budget);
		int sent;
		int ntok;
		sent = 0;
		while (sent < budget) begin
			str_bytes.delete();
			if ($urandom_range(9, 0) == 0) begin
				repeat ($urandom_range(8, 1))
					str_bytes.push_back(8'($urandom_range(255, 0)));
			end else begin
				ntok = $urandom_range(4, 0);
				if (roll(20))
					push_delims();
				for (int t = 0; t < ntok; t++) begin
					if (t != 0)
						push_delims();
					push_token();
				end
				if (roll(35))
					push_delims();
				if (str_bytes.size() == 0)
					str_bytes.push_back(8'($urandom_range(255, 0)));
			end
			foreach (str_bytes[i])
				send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
			sent += str_bytes.size();
		end
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	initial begin : receiver
		int held;
		held = 0;
		forever begin
			@(negedge clk);
			if (held == 0 && hold_cycles_req != 0) begin
				held = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (held != 0) begin
				out_stall <= 1'b1;
				held--;
			end else
				out_stall <= roll(recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_res = '{number, status, last};
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected transaction number %0d status %0d last %0d",
					$time, number, status, last);
			end else begin
				want_res = pending_results.pop_front();
				if (seen_res.number !== want_res.number) begin
					err_count++;
					$display("%0t: number expected %0d actual %0d", $time,
						want_res.number, seen_res.number);
				end
				if (seen_res.status !== want_res.status) begin
					err_count++;
					$display("%0t: status expected %0d actual %0d", $time,
						want_res.status, seen_res.status);
				end
				if (seen_res.last !== want_res.last) begin
					err_count++;
					$display("%0t: last expected %0d actual %0d", $time,
						want_res.last, seen_res.last);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		for (int k = 0; k < 4; k++)
			delim_copy[k] = 64'd0;
		max_count = 16'd0;
		clear_token();
		emit_cnt = 16'd0;
		seen_token = 1'b0;
		// typed rows carry the result; the others go through the predictor
		dir_rows = '{
			'{8'h20,    1'b1, 1'b1, 32'sd0,  dit_pkg::ST_EMPTY,       1'b1},
			'{dit_pkg::CHAR_MINUS, 1'b0, 1'b0, 32'sd0, dit_pkg::ST_NUMBER, 1'b0},
			'{8'h2C,    1'b0, 1'b1, 32'sd0,  dit_pkg::ST_NON_NUMERIC, 1'b0},
			'{dit_pkg::CHAR_PLUS, 1'b0, 1'b0, 32'sd0, dit_pkg::ST_NUMBER, 1'b0},
			'{"7",      1'b1, 1'b1, 32'sd7,  dit_pkg::ST_NUMBER,      1'b1},
			'{8'hFF,    1'b1, 1'b1, 32'sd0,  dit_pkg::ST_NON_NUMERIC, 1'b1},
			'{dit_pkg::CHAR_ZERO, 1'b0, 1'b0, 32'sd0, dit_pkg::ST_NUMBER, 1'b0},
			'{8'h2C,    1'b0, 1'b1, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{8'h2C,    1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{8'h20,    1'b1, 1'b1, 32'sd0,  dit_pkg::ST_END,         1'b1},
			'{8'h00,    1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"5",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{8'h2C,    1'b1, 1'b1, 32'sd0,  dit_pkg::ST_NON_NUMERIC, 1'b1},
			'{dit_pkg::CHAR_MINUS, 1'b0, 1'b0, 32'sd0, dit_pkg::ST_NUMBER, 1'b0},
			'{"2",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"1",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"4",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"7",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"4",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"8",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"3",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"6",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			'{"4",      1'b0, 1'b0, 32'sd0,  dit_pkg::ST_NUMBER,      1'b0},
			// most negative value, no overflow
			'{"8",      1'b1, 1'b1, 32'sh8000_0000, dit_pkg::ST_NUMBER, 1'b1}
		};
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apply_settings(SPACE_COMMA, 64'd0, 64'd0, 64'd0, 16'd0, 0, 0, 0);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].ch, dir_rows[i].eos, dir_rows[i].typed,
				'{dir_rows[i].num, dir_rows[i].st, dir_rows[i].lst});

		apply_settings(SPACE_COMMA, 64'd0, 64'd0, 64'd0, 16'd0, 0, 0, 0);
		random_strings(240);
		apply_settings(SPACE_COMMA, 64'd0, 64'd0, 64'd0, 16'd1, 46, 0, 0);
		random_strings(220);
		// random masks that keep digits and signs; long receiver hold-off
		apply_settings(({$urandom, $urandom} & ~NUMERIC_BITS) | SPACE_COMMA,
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			16'd2, 0, 46, 300);
		random_strings(220);
		apply_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 16'hFFFF, 25, 25, 0);
		random_strings(120);
		apply_settings(64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 0, 0, 0);
		random_strings(200);
		apply_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 16'd3, 25, 25, 0);
		random_strings(200);
		apply_settings(SPACE_COMMA, 64'd0, 64'd0, ALL_ONES, 16'hFFFF, 46, 0, 0);
		random_strings(180);
		apply_settings(64'd1 << 44, 64'd0, 64'd0, 64'd0, 16'd0, 0, 46, 200);
		random_strings(200);

		drain();
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dit_pkg.sv
rtl/dit_front.sv
rtl/dit_queue.sv
rtl/dit_back.sv
rtl/delimited_integer_text_parser.sv
sim/tb.sv
